[design/dqs_pkg.sv]
package dqs_pkg;

    localparam int DATA_W  = 32;
    localparam int COUNT_W = 11;

    typedef enum logic [2:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_BACK   = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_SUM        = 3'd4,
        OP_CLEAR      = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [0:0] {
        FSM_IDLE = 1'b0,
        FSM_POP  = 1'b1
    } fsm_t;

    // controller to datapath
    typedef struct packed {
        logic accept;      // item taken at this edge
        logic finish_pop;  // read data is back, load the pop result
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic pop_read;    // accepted item is a pop that reads the store
        logic out_full;    // result register holds an item not yet taken
    } stat_t;

endpackage

[design/dqs_ctrl.sv]
module dqs_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic           m_ready,
    input  dqs_pkg::stat_t stat,
    output dqs_pkg::cmd_t  cmd
);

    dqs_pkg::fsm_t state_reg;
    dqs_pkg::fsm_t state_next;
    logic          accept;

    // take an item only when the result slot is free or empties at this edge
    assign s_ready = (state_reg == dqs_pkg::FSM_IDLE) && (!stat.out_full || m_ready);
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            dqs_pkg::FSM_IDLE: begin
                if (accept && stat.pop_read) begin
                    state_next = dqs_pkg::FSM_POP;
                end
            end
            dqs_pkg::FSM_POP: begin
                state_next = dqs_pkg::FSM_IDLE;
            end
            default: begin
                state_next = dqs_pkg::FSM_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd.accept     = accept;
        cmd.finish_pop = (state_reg == dqs_pkg::FSM_POP);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dqs_pkg::FSM_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[design/dqs_datapath.sv]
module dqs_datapath #(
    parameter int QUEUE_DEPTH = 1024
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  dqs_pkg::cmd_t                       cmd,
    output dqs_pkg::stat_t                      stat,
    input  logic [2:0]                          s_operation,
    input  logic signed [dqs_pkg::DATA_W-1:0]   s_value,
    input  logic                                m_ready,
    output logic                                m_valid,
    output logic signed [dqs_pkg::DATA_W-1:0]   m_data_out,
    output logic [1:0]                          m_status,
    output logic [dqs_pkg::COUNT_W-1:0]         m_entry_count
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [OCC_W-1:0] FULL_OCC  = OCC_W'(QUEUE_DEPTH);

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
        ring_next = (idx == LAST_IDX) ? '0 : idx + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] idx);
        ring_prev = (idx == '0) ? LAST_IDX : idx - IDX_W'(1);
    endfunction

    logic [dqs_pkg::DATA_W-1:0] mem [QUEUE_DEPTH];

    logic [IDX_W-1:0]             front_reg, front_next;
    logic [IDX_W-1:0]             back_reg, back_next;
    logic [OCC_W-1:0]             occ_reg, occ_next;
    logic [dqs_pkg::DATA_W-1:0]   total_reg, total_next;
    logic [dqs_pkg::DATA_W-1:0]   rd_data_reg;
    logic                         out_valid_reg;
    logic [dqs_pkg::DATA_W-1:0]   out_data_reg;
    dqs_pkg::status_t             out_status_reg;
    logic [dqs_pkg::COUNT_W-1:0]  out_count_reg;

    logic                         wr_en, rd_en, load;
    logic [IDX_W-1:0]             wr_addr, rd_addr;
    logic [dqs_pkg::DATA_W-1:0]   ld_data;
    dqs_pkg::status_t             ld_status;
    logic                         is_full, is_empty;
    logic [OCC_W+dqs_pkg::COUNT_W-1:0] count_wide;

    assign is_full  = (occ_reg == FULL_OCC);
    assign is_empty = (occ_reg == '0);

    always_comb begin
        front_next = front_reg;
        back_next  = back_reg;
        occ_next   = occ_reg;
        total_next = total_reg;
        wr_en      = 1'b0;
        wr_addr    = back_reg;
        rd_en      = 1'b0;
        rd_addr    = front_reg;
        load       = 1'b0;
        ld_data    = '0;
        ld_status  = dqs_pkg::ST_OK;
        if (cmd.accept) begin
            load = 1'b1;
            unique case (dqs_pkg::op_t'(s_operation))
                dqs_pkg::OP_PUSH_BACK: begin
                    if (is_full) begin
                        ld_status = dqs_pkg::ST_FULL;
                    end else begin
                        wr_en      = 1'b1;
                        wr_addr    = back_reg;
                        back_next  = ring_next(back_reg);
                        occ_next   = occ_reg + OCC_W'(1);
                        total_next = total_reg + s_value;
                    end
                end
                dqs_pkg::OP_PUSH_FRONT: begin
                    if (is_full) begin
                        ld_status = dqs_pkg::ST_FULL;
                    end else begin
                        wr_en      = 1'b1;
                        wr_addr    = ring_prev(front_reg);
                        front_next = ring_prev(front_reg);
                        occ_next   = occ_reg + OCC_W'(1);
                        total_next = total_reg + s_value;
                    end
                end
                dqs_pkg::OP_POP_BACK: begin
                    if (is_empty) begin
                        ld_status = dqs_pkg::ST_EMPTY;
                    end else begin
                        load      = 1'b0;
                        rd_en     = 1'b1;
                        rd_addr   = ring_prev(back_reg);
                        back_next = ring_prev(back_reg);
                        occ_next  = occ_reg - OCC_W'(1);
                    end
                end
                dqs_pkg::OP_POP_FRONT: begin
                    if (is_empty) begin
                        ld_status = dqs_pkg::ST_EMPTY;
                    end else begin
                        load       = 1'b0;
                        rd_en      = 1'b1;
                        rd_addr    = front_reg;
                        front_next = ring_next(front_reg);
                        occ_next   = occ_reg - OCC_W'(1);
                    end
                end
                dqs_pkg::OP_SUM: begin
                    if (is_empty) begin
                        ld_status = dqs_pkg::ST_EMPTY;
                    end else begin
                        ld_data = total_reg;
                    end
                end
                dqs_pkg::OP_CLEAR: begin
                    front_next = '0;
                    back_next  = '0;
                    occ_next   = '0;
                    total_next = '0;
                end
                default: begin
                end
            endcase
        end
        if (cmd.finish_pop) begin
            load       = 1'b1;
            ld_data    = rd_data_reg;
            total_next = total_reg - rd_data_reg;
        end
    end

    // count field is 11 bits whatever the depth: widen, then cut
    assign count_wide = {{dqs_pkg::COUNT_W{1'b0}}, occ_next};

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= s_value;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg     <= '0;
            back_reg      <= '0;
            occ_reg       <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            front_reg <= front_next;
            back_reg  <= back_next;
            occ_reg   <= occ_next;
            total_reg <= total_next;
            if (load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_data_reg   <= ld_data;
            out_status_reg <= ld_status;
            out_count_reg  <= count_wide[dqs_pkg::COUNT_W-1:0];
        end
    end

    assign stat.pop_read = rd_en;
    assign stat.out_full = out_valid_reg;

    assign m_valid       = out_valid_reg;
    assign m_data_out    = out_data_reg;
    assign m_status      = out_status_reg;
    assign m_entry_count = out_count_reg;

endmodule

[design/double_ended_queue_with_sum_unit.sv]
// Push, sum, clear and error cases load the result register from the accepted item;
// a pop that reads the store passes the read register first, then the result register.
// One item per cycle while results are taken, except a pop, which holds the input in its pop
// state because the ring store has a registered read port.
// Reset: aresetn is synchronous and active low; it empties the queue and zeroes the sum.
// The store itself is not cleared, so the block accepts items straight after reset.
module double_ended_queue_with_sum_unit #(
    parameter int QUEUE_DEPTH = 1024
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input channel: one operation per item
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [2:0]                         s_operation,
    input  logic signed [dqs_pkg::DATA_W-1:0]  s_value,
    // result channel: one result item per input item
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [dqs_pkg::DATA_W-1:0]  m_data_out,
    output logic [1:0]                         m_status,
    output logic [dqs_pkg::COUNT_W-1:0]        m_entry_count
);

    dqs_pkg::cmd_t  cmd;
    dqs_pkg::stat_t stat;

    // Controller: decide when an item is taken and sequence the pop read.
    // The next item is accepted while the result register still holds an item,
    // provided that item leaves at the same edge.
    dqs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Datapath: ring store, front and back pointers, occupancy, running total
    // and the result register. The total wraps modulo 2^32; a pop subtracts the
    // value once it is read back from the store.
    dqs_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .s_operation   (s_operation),
        .s_value       (s_value),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_data_out    (m_data_out),
        .m_status      (m_status),
        .m_entry_count (m_entry_count)
    );

endmodule

[tb/deque_sum_checker.sv]
module deque_sum_checker #(
    parameter int QUEUE_DEPTH = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic [2:0]                        s_operation,
    input  logic signed [dqs_pkg::DATA_W-1:0] s_value,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic signed [dqs_pkg::DATA_W-1:0] m_data_out,
    input  logic [1:0]                        m_status,
    input  logic [dqs_pkg::COUNT_W-1:0]       m_entry_count,
    output int                                error_count,
    output int                                pending_count
);

    import dqs_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0]  data;
        status_t            status;
        logic [COUNT_W-1:0] count;
    } deque_reply_t;

    // shadow copy of the ring and its bookkeeping
    logic [DATA_W-1:0] ring_words [QUEUE_DEPTH];
    int unsigned       head_slot;
    int unsigned       tail_slot;
    int unsigned       fill_level;
    logic [DATA_W-1:0] running_sum;

    deque_reply_t predicted_replies [$];

    function automatic deque_reply_t apply_deque_op(input logic [2:0] op,
                                                    input logic [DATA_W-1:0] val);
        deque_reply_t r;
        r.data   = '0;
        r.status = ST_OK;
        case (op)
            OP_PUSH_BACK, OP_PUSH_FRONT: begin
                if (fill_level >= QUEUE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    if (op == OP_PUSH_BACK) begin
                        ring_words[tail_slot] = val;
                        tail_slot = (tail_slot + 1) % QUEUE_DEPTH;
                    end else begin
                        head_slot = (head_slot + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
                        ring_words[head_slot] = val;
                    end
                    fill_level++;
                    running_sum += val;
                end
            end
            OP_POP_BACK, OP_POP_FRONT: begin
                if (fill_level == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    if (op == OP_POP_BACK) begin
                        tail_slot = (tail_slot + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
                        r.data = ring_words[tail_slot];
                    end else begin
                        r.data = ring_words[head_slot];
                        head_slot = (head_slot + 1) % QUEUE_DEPTH;
                    end
                    fill_level--;
                    running_sum -= r.data;
                end
            end
            OP_SUM: begin
                if (fill_level == 0)
                    r.status = ST_EMPTY;
                else
                    r.data = running_sum;
            end
            OP_CLEAR: begin
                head_slot   = 0;
                tail_slot   = 0;
                fill_level  = 0;
                running_sum = '0;
            end
            default: ;
        endcase
        r.count = fill_level[COUNT_W-1:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        deque_reply_t want;
        if (!aresetn) begin
            head_slot   = 0;
            tail_slot   = 0;
            fill_level  = 0;
            running_sum = '0;
            predicted_replies.delete();
        end else begin
            // compare first: a result never belongs to an item taken at the same edge
            if (m_valid && m_ready) begin
                if (predicted_replies.size() == 0) begin
                    $error("unexpected result: data_out %h status %0d entry_count %0d",
                           m_data_out, m_status, m_entry_count);
                    error_count++;
                end else begin
                    want = predicted_replies.pop_front();
                    if (m_data_out !== want.data) begin
                        $error("data_out mismatch: expected %h, actual %h",
                               want.data, m_data_out);
                        error_count++;
                    end
                    if (m_status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, m_status);
                        error_count++;
                    end
                    if (m_entry_count !== want.count) begin
                        $error("entry_count mismatch: expected %0d, actual %0d",
                               want.count, m_entry_count);
                        error_count++;
                    end
                end
            end
            if (s_valid && s_ready)
                predicted_replies.insert(predicted_replies.size(),
                                         apply_deque_op(s_operation, s_value));
        end
        pending_count = predicted_replies.size();
    end

endmodule

[tb/tb_double_ended_queue_with_sum_unit.sv]
module tb_double_ended_queue_with_sum_unit;

    import dqs_pkg::*;

    localparam int QUEUE_DEPTH  = 1024;
    localparam int RANDOM_ITEMS = 50;
    // receiver hold-off, long enough to back the block up into its input
    localparam int LONG_HOLD    = 300;
    // cycles without any handshake before the run is called hung
    localparam int QUIET_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 8;

    // codes outside the defined operation set
    localparam logic [2:0] OP_UNUSED_6 = 3'd6;
    localparam logic [2:0] OP_UNUSED_7 = 3'd7;

    logic                      aclk;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    logic [2:0]                s_operation;
    logic signed [DATA_W-1:0]  s_value;
    logic                      m_valid;
    logic                      m_ready;
    logic signed [DATA_W-1:0]  m_data_out;
    logic [1:0]                m_status;
    logic [COUNT_W-1:0]        m_entry_count;

    int   error_count;
    int   pending_count;
    // calm: neither side idles; hold_off_req: ask the receiver for its long stall
    logic calm;
    logic hold_off_req;
    int   quiet_cycles;

    double_ended_queue_with_sum_unit #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data_out    (m_data_out),
        .m_status      (m_status),
        .m_entry_count (m_entry_count)
    );

    deque_sum_checker #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) deque_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data_out    (m_data_out),
        .m_status      (m_status),
        .m_entry_count (m_entry_count),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Receiver: decide m_ready at each falling edge. Honour one long hold-off
    // when asked, otherwise stall with a chance of 11 in a hundred unless calm.
    initial begin
        int hold_left;
        bit hold_off_done;
        hold_left     = 0;
        hold_off_done = 1'b0;
        m_ready       = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (hold_off_req && !hold_off_done) begin
                hold_off_done = 1'b1;
                hold_left     = LONG_HOLD - 1;
                m_ready       <= 1'b0;
            end else if (calm) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= 11);
            end
        end
    end

    // Watchdog: count cycles in which neither channel moves an item.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one item: idle at random first, then hold valid and payload
    // until the handshake, and return at the next falling edge.
    task automatic send_op(input logic [2:0] op, input logic [DATA_W-1:0] val);
        while (!calm && $urandom_range(0, 99) < 11) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_value     <= val;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Drop valid and wait until every predicted result has been taken.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending_count != 0);
    endtask

    // Bias values towards the extremes so the running sum wraps often.
    function automatic logic [DATA_W-1:0] pick_value();
        logic [DATA_W-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = 32'h7FFF_FFFF;
            1:       v = 32'h8000_0000;
            2:       v = 32'hFFFF_FFFF;
            3:       v = '0;
            4:       v = $urandom_range(0, 15);
            default: v = $urandom();
        endcase
        return v;
    endfunction

    function automatic logic [2:0] pick_mixed_op();
        int w;
        w = $urandom_range(0, 99);
        if (w < 22)      return OP_PUSH_BACK;
        else if (w < 44) return OP_PUSH_FRONT;
        else if (w < 62) return OP_POP_BACK;
        else if (w < 80) return OP_POP_FRONT;
        else if (w < 92) return OP_SUM;
        else if (w < 97) return OP_CLEAR;
        else if (w < 99) return OP_UNUSED_6;
        else             return OP_UNUSED_7;
    endfunction

    initial begin
        int         sent;
        int         kind;
        int         len;
        logic [2:0] op;

        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_operation  = '0;
        s_value      = '0;
        calm         = 1'b0;
        hold_off_req = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: errors on the empty queue, unused codes, sum wraparound,
        // both ends, front pointer wrapping below slot zero, clear.
        send_op(OP_POP_BACK,   $urandom());
        send_op(OP_POP_FRONT,  $urandom());
        send_op(OP_SUM,        $urandom());
        send_op(OP_UNUSED_6,   $urandom());
        send_op(OP_UNUSED_7,   $urandom());
        send_op(OP_CLEAR,      $urandom());
        send_op(OP_PUSH_BACK,  32'h7FFF_FFFF);
        send_op(OP_PUSH_BACK,  32'h0000_0001);
        send_op(OP_SUM,        '0);
        send_op(OP_PUSH_FRONT, 32'h8000_0000);
        send_op(OP_PUSH_FRONT, 32'hFFFF_FFFF);
        send_op(OP_SUM,        $urandom());
        send_op(OP_UNUSED_6,   $urandom());
        send_op(OP_POP_FRONT,  $urandom());
        send_op(OP_POP_BACK,   $urandom());
        send_op(OP_PUSH_BACK,  '0);
        send_op(OP_POP_FRONT,  $urandom());
        send_op(OP_SUM,        $urandom());
        send_op(OP_CLEAR,      $urandom());
        send_op(OP_SUM,        $urandom());
        send_op(OP_POP_BACK,   $urandom());
        send_op(OP_PUSH_FRONT, 32'h5555_5555);
        send_op(OP_POP_BACK,   $urandom());
        send_op(OP_PUSH_BACK,  32'hAAAA_AAAA);
        send_op(OP_POP_FRONT,  $urandom());

        // Pause the sender until everything is back.
        wait_drained();

        // Fill to capacity from both ends while the receiver holds off,
        // so the block backs up and stalls its input. Once the hold-off is
        // over, run a long calm stretch with no idling on either side.
        hold_off_req <= 1'b1;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            calm <= (i >= 300 && i < 800);
            send_op($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT, pick_value());
        end
        calm <= 1'b0;
        send_op(OP_PUSH_BACK,  $urandom());
        send_op(OP_PUSH_FRONT, $urandom());
        send_op(OP_SUM,        $urandom());
        send_op(OP_POP_FRONT,  $urandom());
        send_op(OP_PUSH_BACK,  pick_value());
        send_op(OP_PUSH_FRONT, $urandom());
        send_op(OP_POP_BACK,   $urandom());
        send_op(OP_PUSH_FRONT, pick_value());
        send_op(OP_PUSH_BACK,  $urandom());
        for (int i = 0; i < 40; i++)
            send_op(i[0] ? OP_POP_BACK : OP_POP_FRONT, $urandom());
        send_op(OP_SUM,   $urandom());
        send_op(OP_CLEAR, $urandom());
        wait_drained();

        // Random bursts: push runs, pop runs and mixed traffic.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 9);
            len  = $urandom_range(8, 40);
            for (int k = 0; k < len; k++) begin
                if (kind < 2)
                    op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
                else if (kind < 4)
                    op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
                else
                    op = pick_mixed_op();
                send_op(op, pick_value());
                sent++;
            end
        end

        // Drain, let the pipeline settle, then give the verdict.
        wait_drained();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
